@@ src/sbf_pkg.sv @@
`timescale 1ns / 1ps
package sbf_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;

  // Accepted footer codes.
  localparam logic [7:0] FOOTER_A = 8'h00;
  localparam logic [7:0] FOOTER_B = 8'h04;
  localparam logic [7:0] FOOTER_C = 8'h14;
  localparam logic [7:0] FOOTER_D = 8'h24;
  localparam logic [7:0] FOOTER_E = 8'h34;

  localparam int DATA_BYTES = 22;
  localparam int DATA_W     = DATA_BYTES * 8;
  localparam int CH_W       = 11;
  localparam int IDX_W      = 5;

  // Byte positions within a frame, counted with the header as byte 0.
  localparam logic [IDX_W-1:0] POS_IDLE      = 5'd0;
  localparam logic [IDX_W-1:0] POS_LAST_DATA = 5'd22;
  localparam logic [IDX_W-1:0] POS_FLAGS     = 5'd23;
  localparam logic [IDX_W-1:0] POS_FOOTER    = 5'd24;

  // Result channel numbers.
  localparam logic [IDX_W-1:0] CH_DIGITAL_0 = 5'd16;
  localparam logic [IDX_W-1:0] CH_DIGITAL_1 = 5'd17;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              failsafe;
    logic              frame_lost;
    logic [1:0]        digital;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_push_t;

  function automatic logic footer_ok(input logic [7:0] b);
    return (b == FOOTER_A) || (b == FOOTER_B) || (b == FOOTER_C) ||
           (b == FOOTER_D) || (b == FOOTER_E);
  endfunction

endpackage

@@ src/sbf_if.sv @@
`timescale 1ns / 1ps
interface sbf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbf_chan_if;
  logic                         valid;
  logic                         ready;
  logic [sbf_pkg::IDX_W-1:0]    channel_index;
  logic [sbf_pkg::CH_W-1:0]     channel_value;
  logic                         frame_lost;
  logic                         failsafe;
  logic                         last_of_frame;

  modport source (output valid, output channel_index, output channel_value,
                  output frame_lost, output failsafe, output last_of_frame,
                  input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input frame_lost, input failsafe, input last_of_frame,
                output ready);
endinterface

@@ src/sbf_front.sv @@
`timescale 1ns / 1ps
module sbf_front (
  input  logic                 clk,
  input  logic                 rst,
  sbf_rx_if.sink               rx,
  input  logic                 full,
  output sbf_pkg::frame_push_t push
);

  logic [sbf_pkg::IDX_W-1:0]  count;
  logic [sbf_pkg::DATA_W-1:0] data;
  logic [7:0]                 flags;
  logic                       accept;

  // Only the footer beat needs room in the queue.
  assign rx.ready = !((count == sbf_pkg::POS_FOOTER) && full);
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= sbf_pkg::POS_IDLE;
    end else if (accept) begin
      if (count == sbf_pkg::POS_IDLE) begin
        count <= (rx.rx_byte == sbf_pkg::HEADER_BYTE) ? 5'd1 : sbf_pkg::POS_IDLE;
      end else if (count == sbf_pkg::POS_FOOTER) begin
        count <= sbf_pkg::POS_IDLE;
      end else begin
        count <= count + 5'd1;
      end
    end
  end

  // Channel bytes shift in from the top so byte 1 ends up in the low bits.
  always_ff @(posedge clk) begin
    if (accept && (count != sbf_pkg::POS_IDLE) && (count <= sbf_pkg::POS_LAST_DATA)) begin
      data <= {rx.rx_byte, data[sbf_pkg::DATA_W-1:8]};
    end
    if (accept && (count == sbf_pkg::POS_FLAGS)) begin
      flags <= rx.rx_byte;
    end
  end

  always_comb begin
    push.valid            = accept && (count == sbf_pkg::POS_FOOTER) &&
                            sbf_pkg::footer_ok(rx.rx_byte);
    push.frame.data       = data;
    push.frame.failsafe   = flags[3];
    push.frame.frame_lost = flags[2];
    push.frame.digital    = flags[1:0];
  end

endmodule

@@ src/sbf_fifo.sv @@
`timescale 1ns / 1ps
module sbf_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  sbf_pkg::frame_push_t push,
  input  logic                 pop,
  output logic                 full,
  output logic                 avail,
  output sbf_pkg::frame_t      head
);

  sbf_pkg::frame_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign full  = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push.valid && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push.valid) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.frame;
    end
  end

endmodule

@@ src/sbf_back.sv @@
`timescale 1ns / 1ps
module sbf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  sbf_pkg::frame_t head,
  output logic            pop,
  sbf_chan_if.source      chan
);

  logic                       busy;
  logic [sbf_pkg::IDX_W-1:0]  ch;
  logic [sbf_pkg::DATA_W-1:0] data;
  logic                       lost;
  logic                       fs;
  logic [1:0]                 digital;
  logic                       advance;
  logic [sbf_pkg::CH_W-1:0]   value_next;

  logic                       res_valid;
  logic [sbf_pkg::IDX_W-1:0]  res_index;
  logic [sbf_pkg::CH_W-1:0]   res_value;
  logic                       res_lost;
  logic                       res_fs;
  logic                       res_last;

  assign advance = busy && (!res_valid || chan.ready);
  assign pop     = !busy && avail;

  always_comb begin
    if (ch == sbf_pkg::CH_DIGITAL_0) begin
      value_next = {{(sbf_pkg::CH_W-1){1'b0}}, digital[0]};
    end else if (ch == sbf_pkg::CH_DIGITAL_1) begin
      value_next = {{(sbf_pkg::CH_W-1){1'b0}}, digital[1]};
    end else begin
      value_next = data[sbf_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ch        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        ch   <= '0;
      end else if (advance) begin
        ch <= ch + 5'd1;
        if (ch == sbf_pkg::CH_DIGITAL_1) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (chan.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Each emitted proportional channel shifts the packed word down by one field.
  always_ff @(posedge clk) begin
    if (pop) begin
      data    <= head.data;
      lost    <= head.frame_lost;
      fs      <= head.failsafe;
      digital <= head.digital;
    end else if (advance) begin
      data <= data >> sbf_pkg::CH_W;
    end
    if (advance) begin
      res_index <= ch;
      res_value <= value_next;
      res_lost  <= lost;
      res_fs    <= fs;
      res_last  <= (ch == sbf_pkg::CH_DIGITAL_1);
    end
  end

  assign chan.valid         = res_valid;
  assign chan.channel_index = res_index;
  assign chan.channel_value = res_value;
  assign chan.frame_lost    = res_lost;
  assign chan.failsafe      = res_fs;
  assign chan.last_of_frame = res_last;

endmodule

@@ src/sbus_frame_decoder.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Payload
// rx       in   rx_byte[7:0]
// chan     out  channel_index[4:0], channel_value[10:0], frame_lost, failsafe,
//               last_of_frame
//
// One byte is taken per cycle unless rx stalls; a frame of 25 bytes yields 18 beats
// on chan, one per cycle while chan.ready is held, once the frame has left the queue.
// A two-entry frame queue sits between the byte collector and the channel
// unpacker, so the unpacker drains a frame while the next one arrives.
// rx stalls only on a footer beat while both queue entries are taken.
// Synchronous active-high reset returns to waiting for a header; no clearing pass.
module sbus_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  sbf_rx_if.sink      rx,
  sbf_chan_if.source  chan
);

  sbf_pkg::frame_push_t push;
  sbf_pkg::frame_t      head;
  logic                 full;
  logic                 avail;
  logic                 pop;

  sbf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .full (full),
    .push (push)
  );

  sbf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .full  (full),
    .avail (avail),
    .head  (head)
  );

  sbf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .head  (head),
    .pop   (pop),
    .chan  (chan)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (!full || pop))
    else $error("frame pushed into a full queue");

  a_last_marks_ch17: assert property (@(posedge clk) disable iff (rst)
    chan.valid |-> (chan.last_of_frame == (chan.channel_index == sbf_pkg::CH_DIGITAL_1)))
    else $error("last_of_frame does not match the final channel");

  a_digital_range: assert property (@(posedge clk) disable iff (rst)
    (chan.valid && (chan.channel_index >= sbf_pkg::CH_DIGITAL_0)) |->
      (chan.channel_value[sbf_pkg::CH_W-1:1] == '0))
    else $error("digital channel value out of range");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (chan.valid && chan.ready && !chan.last_of_frame) |=>
      (!chan.valid || (chan.channel_index == $past(chan.channel_index) + 5'd1)))
    else $error("channel index skipped within a frame");

endmodule

@@ dv/sbus_frame_decoder_tb.sv @@
`timescale 1ns / 1ps
module sbus_frame_decoder_tb;

  localparam int FRAME_LEN    = 25;
  localparam int STORE_LEN    = FRAME_LEN - 1;
  localparam int NUM_PROP     = 16;
  localparam int ITEM_TARGET  = 270;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_SLACK  = 24;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [sbf_pkg::IDX_W-1:0] idx;
    logic [sbf_pkg::CH_W-1:0]  val;
    logic                      lost;
    logic                      fs;
    logic                      last;
  } chan_beat_t;

  class sbus_channel_scoreboard;
    int unsigned fill;
    logic [7:0]  store [STORE_LEN];
    chan_beat_t  want_q [$];
    int unsigned errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function bit footer_good(logic [7:0] f);
      return (f == sbf_pkg::FOOTER_A) || (f == sbf_pkg::FOOTER_B) ||
             (f == sbf_pkg::FOOTER_C) || (f == sbf_pkg::FOOTER_D) ||
             (f == sbf_pkg::FOOTER_E);
    endfunction

    // Tracks the frame collector and queues the 18 channel beats of every
    // frame that closes with a good footer.
    function void note_byte(logic [7:0] b);
      logic [sbf_pkg::DATA_W-1:0] stream;
      logic [7:0]                 flags;
      chan_beat_t                 e;
      if (fill == 0) begin
        fill = (b == sbf_pkg::HEADER_BYTE) ? 1 : 0;
        return;
      end
      store[fill-1] = b;
      fill++;
      if (fill < FRAME_LEN) return;
      fill = 0;
      if (!footer_good(store[sbf_pkg::POS_FOOTER-1])) return;
      for (int k = 0; k < sbf_pkg::DATA_BYTES; k++) stream[8*k +: 8] = store[k];
      flags = store[sbf_pkg::POS_FLAGS-1];
      e.lost = flags[2];
      e.fs   = flags[3];
      e.last = 1'b0;
      for (int ch = 0; ch < NUM_PROP; ch++) begin
        e.idx = sbf_pkg::IDX_W'(ch);
        e.val = stream[sbf_pkg::CH_W*ch +: sbf_pkg::CH_W];
        want_q.push_back(e);
      end
      e.idx = sbf_pkg::CH_DIGITAL_0;
      e.val = sbf_pkg::CH_W'(flags[0]);
      want_q.push_back(e);
      e.idx  = sbf_pkg::CH_DIGITAL_1;
      e.val  = sbf_pkg::CH_W'(flags[1]);
      e.last = 1'b1;
      want_q.push_back(e);
    endfunction

    function void report(string what, chan_beat_t want, chan_beat_t got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display({"%0t %s: expected idx=%0d val=%0d lost=%b fs=%b last=%b,",
                  " got idx=%0d val=%0d lost=%b fs=%b last=%b"},
                 $realtime, what, want.idx, want.val, want.lost, want.fs, want.last,
                 got.idx, got.val, got.lost, got.fs, got.last);
    endfunction

    function void check_beat(chan_beat_t got);
      chan_beat_t want;
      if (want_q.size() == 0) begin
        report("unexpected beat", '0, got);
        return;
      end
      want = want_q.pop_front();
      if (got.idx !== want.idx || got.val !== want.val || got.lost !== want.lost ||
          got.fs !== want.fs || got.last !== want.last)
        report("channel mismatch", want, got);
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  sbf_rx_if   rx_bus ();
  sbf_chan_if chan_bus ();

  sbus_frame_decoder DUT (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_bus.sink),
    .chan (chan_bus.source)
  );

  sbus_channel_scoreboard sb = new();

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned bytes_fed = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("sbus_frame_decoder regression: fail");
    $finish;
  end

  // Channel receiver: checks every accepted beat and throttles ready.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    chan_beat_t  got;
    hold_left = 0;
    hold_seen = 0;
    chan_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (chan_bus.valid === 1'b1 && chan_bus.ready === 1'b1) begin
        got.idx  = chan_bus.channel_index;
        got.val  = chan_bus.channel_value;
        got.lost = chan_bus.frame_lost;
        got.fs   = chan_bus.failsafe;
        got.last = chan_bus.last_of_frame;
        sb.check_beat(got);
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        chan_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        chan_bus.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 32) begin
        chan_bus.ready <= 1'b0;
      end else begin
        chan_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_on && $urandom_range(0, 99) < 32) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk);
    while (rx_bus.ready !== 1'b1) @(posedge clk);
    sb.note_byte(b);
    bytes_fed++;
  endtask

  task automatic send_frame(input logic [sbf_pkg::DATA_W-1:0] payload,
                            input logic [7:0] flags, input logic [7:0] footer);
    send_byte(sbf_pkg::HEADER_BYTE);
    for (int k = 0; k < sbf_pkg::DATA_BYTES; k++) send_byte(payload[8*k +: 8]);
    send_byte(flags);
    send_byte(footer);
  endtask

  function automatic logic [7:0] good_footer_pick(int k);
    case (k % 5)
      0: return sbf_pkg::FOOTER_A;
      1: return sbf_pkg::FOOTER_B;
      2: return sbf_pkg::FOOTER_C;
      3: return sbf_pkg::FOOTER_D;
      default: return sbf_pkg::FOOTER_E;
    endcase
  endfunction

  // Channel values lean toward the ends of their range now and then.
  task automatic send_random_frame(input logic [7:0] footer);
    logic [sbf_pkg::DATA_W-1:0] payload;
    int unsigned                pick;
    for (int ch = 0; ch < NUM_PROP; ch++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) payload[sbf_pkg::CH_W*ch +: sbf_pkg::CH_W] = '0;
      else if (pick == 1) payload[sbf_pkg::CH_W*ch +: sbf_pkg::CH_W] = '1;
      else payload[sbf_pkg::CH_W*ch +: sbf_pkg::CH_W] = sbf_pkg::CH_W'($urandom);
    end
    send_frame(payload, 8'($urandom), footer);
  endtask

  task automatic wait_drained();
    rx_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  initial begin
    logic [7:0]                 f;
    logic [sbf_pkg::DATA_W-1:0] payload;
    rst            <= 1'b1;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle bytes other than the header are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sbf_pkg::HEADER_BYTE ^ 8'h01);
    // Every channel at full scale, all flag bits set including the unused ones.
    send_frame('1, 8'hFF, sbf_pkg::FOOTER_E);
    // Header values inside the frame are plain data.
    send_frame({sbf_pkg::DATA_BYTES{sbf_pkg::HEADER_BYTE}}, 8'h00, sbf_pkg::FOOTER_A);
    // A bad footer drops the frame.
    payload = sbf_pkg::DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom});
    send_frame(payload, 8'h0C, sbf_pkg::FOOTER_E ^ 8'h01);

    // Stall the receiver and keep the bytes coming until rx backs up.
    hold_requests++;
    tx_idle_on = 1'b0;
    for (int k = 0; k < 4; k++) send_random_frame(good_footer_pick(k));
    tx_idle_on = 1'b1;

    wait_drained();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (3) send_random_frame(good_footer_pick($urandom_range(0, 4)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    while (bytes_fed < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if ($urandom_range(0, 6) == 0) begin
        f = 8'($urandom);
        if (sb.footer_good(f)) f = f ^ 8'h01;
        send_random_frame(f);
      end else begin
        send_random_frame(good_footer_pick($urandom_range(0, 4)));
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sbus_frame_decoder regression: pass");
    end else begin
      $display("sbus_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sbf_pkg.sv
src/sbf_if.sv
src/sbf_front.sv
src/sbf_fifo.sv
src/sbf_back.sv
src/sbus_frame_decoder.sv
dv/sbus_frame_decoder_tb.sv
